// ----- design/vsni_pkg.sv -----
// Shared types and constants for the six-neighbour voxel index block.
package vsni_pkg;

  localparam int CNT_W     = 9;
  localparam int COORD_W   = 8;
  localparam int IDX_W     = 17;
  localparam int INT_W     = 16;
  localparam int DIR_W     = 3;
  localparam int STAT_W    = 2;
  localparam int REQ_W     = 2;
  localparam int PLANE_W   = 18;
  localparam int POS_W     = 27;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]   ROW_RST   = 9'd64;
  localparam logic [CNT_W-1:0]   COL_RST   = 9'd64;
  localparam logic [CNT_W-1:0]   SLICE_RST = 9'd16;
  localparam logic [PLANE_W-1:0] PLANE_RST = 18'd4096;
  localparam logic [POS_W-1:0]   VOL_RST   = 27'd65536;

  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DROP = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  localparam logic [DIR_W-1:0] DIR_SLICE_LO = 3'd0;
  localparam logic [DIR_W-1:0] DIR_COL_LO   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_ROW_LO   = 3'd2;
  localparam logic [DIR_W-1:0] DIR_ROW_HI   = 3'd3;
  localparam logic [DIR_W-1:0] DIR_COL_HI   = 3'd4;
  localparam logic [DIR_W-1:0] DIR_SLICE_HI = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic               voxel_valid;
    logic [INT_W-1:0]   intensity;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] slice;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  self_index;
    logic [INT_W-1:0]  self_intensity;
    logic [DIR_W-1:0]  direction;
    logic              neighbour_present;
    logic [IDX_W-1:0]  neighbour_index;
    logic [INT_W-1:0]  neighbour_intensity;
    logic              last;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             load;
    logic             restart;
    logic             latch;
    logic             mul1;
    logic             mul2;
    logic             bad;
    logic             self_rd;
    logic             nbr_rd;
    logic [DIR_W-1:0] dir;
    logic             last;
  } dp_cmd_t;

endpackage

// ----- design/vsni_ctrl.sv -----
// Controller state machine: sequences loads, restarts, queries and configuration settling.
module vsni_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [vsni_pkg::REQ_W-1:0] req_type,
  input  logic                      cfg_wr,
  input  logic                      query_ok,
  output logic                      busy,
  output logic                      idle,
  output vsni_pkg::dp_cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CFG1  = 7'b0000010,
    S_CFG2  = 7'b0000100,
    S_MUL1  = 7'b0001000,
    S_MUL2  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_NBR   = 7'b1000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [vsni_pkg::DIR_W-1:0]    dir_r, dir_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dir_r   <= vsni_pkg::DIR_SLICE_LO;
    end else begin
      state_r <= state_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (req_type)
            vsni_pkg::REQ_LOAD:    cmd.load = 1'b1;
            vsni_pkg::REQ_RESTART: cmd.restart = 1'b1;
            vsni_pkg::REQ_QUERY: begin
              cmd.latch = 1'b1;
              state_nxt = S_MUL1;
            end
            default: ;
          endcase
        end else if (cfg_wr) begin
          // let the plane and volume products settle
          state_nxt = S_CFG1;
        end
      end
      S_CFG1: state_nxt = S_CFG2;
      S_CFG2: state_nxt = S_IDLE;
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (query_ok) begin
          cmd.self_rd = 1'b1;
          dir_nxt     = vsni_pkg::DIR_SLICE_LO;
          state_nxt   = S_NBR;
        end else begin
          cmd.bad   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_NBR: begin
        cmd.nbr_rd = 1'b1;
        cmd.dir    = dir_r;
        cmd.last   = (dir_r == vsni_pkg::DIR_SLICE_HI);
        if (dir_r == vsni_pkg::DIR_SLICE_HI) begin
          state_nxt = S_IDLE;
        end else begin
          dir_nxt = dir_r + vsni_pkg::DIR_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);
  assign busy = ~idle;

endmodule

// ----- design/vsni_dp.sv -----
// Datapath: voxel stores, load counters, position arithmetic and result pipeline.
module vsni_dp #(
  parameter int MAX_VOXELS = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vsni_pkg::dp_cmd_t             cmd,
  input  vsni_pkg::in_word_t            in_word,
  input  logic [vsni_pkg::CNT_W-1:0]    row_cnt,
  input  logic [vsni_pkg::CNT_W-1:0]    col_cnt,
  input  logic [vsni_pkg::CNT_W-1:0]    slice_cnt,
  input  logic [vsni_pkg::PLANE_W-1:0]  plane,
  input  logic [vsni_pkg::POS_W-1:0]    vol,
  output logic                          query_ok,
  output logic                          out_valid,
  output vsni_pkg::out_word_t           out_word
);

  localparam int AW = $clog2(MAX_VOXELS);
  localparam int LW = AW + 1;
  localparam int XW = (LW > vsni_pkg::POS_W) ? LW : vsni_pkg::POS_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_VOXELS);

  typedef struct packed {
    logic                          vld;
    logic                          self_cap;
    logic                          nbr;
    logic                          hit;
    logic [vsni_pkg::DIR_W-1:0]    dir;
    logic                          last;
    logic [vsni_pkg::STAT_W-1:0]   status;
    logic [vsni_pkg::IDX_W-1:0]    sidx;
    logic [vsni_pkg::INT_W-1:0]    sint;
  } tag_t;

  logic [vsni_pkg::IDX_W-1:0]   idx_mem [MAX_VOXELS];
  logic [vsni_pkg::INT_W-1:0]   int_mem [MAX_VOXELS];

  logic [LW-1:0]                lp_r, lp_nxt;
  logic [vsni_pkg::IDX_W-1:0]   vc_r, vc_nxt;
  logic [vsni_pkg::COORD_W-1:0] qr_r, qc_r, qs_r;
  logic                         oob_r;
  logic [vsni_pkg::PLANE_W-1:0] m1_r, m1_nxt;
  logic [vsni_pkg::POS_W-1:0]   pos_r, pos_nxt;
  tag_t                         tag_a_r, tag_nxt;
  logic [vsni_pkg::IDX_W-1:0]   rd_idx_r;
  logic [vsni_pkg::INT_W-1:0]   rd_int_r;
  logic [vsni_pkg::IDX_W-1:0]   self_idx_r;
  logic [vsni_pkg::INT_W-1:0]   self_int_r;
  logic                         out_vld_r;
  vsni_pkg::out_word_t          out_word_r, out_nxt;

  logic [XW-1:0]                lp_x, pos_x, np_x, vol_x;
  logic                         cap_ok, wr_en, rd_en, in_vol, hit;
  logic [vsni_pkg::IDX_W-1:0]   vc_inc, load_idx;
  logic [vsni_pkg::CNT_W-1:0]   r_inc, c_inc, s_inc;
  logic [vsni_pkg::POS_W-1:0]   np;
  logic [AW-1:0]                rd_addr;

  assign lp_x   = XW'(lp_r);
  assign pos_x  = XW'(pos_r);
  assign np_x   = XW'(np);
  assign vol_x  = XW'(vol);
  assign cap_ok = (lp_x < vol_x) && (lp_x < MAX_X);
  assign wr_en  = cmd.load && cap_ok;
  assign vc_inc = vc_r + vsni_pkg::IDX_W'(1);
  assign load_idx = in_word.voxel_valid ? vc_inc : '0;

  assign query_ok = !oob_r && (pos_x < lp_x);

  // position arithmetic: (slice * cols + col) * rows + row, one multiply per cycle
  assign m1_nxt  = vsni_pkg::PLANE_W'(qs_r) * vsni_pkg::PLANE_W'(col_cnt)
                 + vsni_pkg::PLANE_W'(qc_r);
  assign pos_nxt = vsni_pkg::POS_W'(m1_r) * vsni_pkg::POS_W'(row_cnt)
                 + vsni_pkg::POS_W'(qr_r);

  assign r_inc = {1'b0, qr_r} + vsni_pkg::CNT_W'(1);
  assign c_inc = {1'b0, qc_r} + vsni_pkg::CNT_W'(1);
  assign s_inc = {1'b0, qs_r} + vsni_pkg::CNT_W'(1);

  // neighbour position is an offset from the queried one
  always_comb begin
    in_vol = 1'b0;
    np     = pos_r;
    case (cmd.dir)
      vsni_pkg::DIR_SLICE_LO: begin
        in_vol = (qs_r != '0);
        np     = pos_r - vsni_pkg::POS_W'(plane);
      end
      vsni_pkg::DIR_COL_LO: begin
        in_vol = (qc_r != '0);
        np     = pos_r - vsni_pkg::POS_W'(row_cnt);
      end
      vsni_pkg::DIR_ROW_LO: begin
        in_vol = (qr_r != '0);
        np     = pos_r - vsni_pkg::POS_W'(1);
      end
      vsni_pkg::DIR_ROW_HI: begin
        in_vol = (r_inc < row_cnt);
        np     = pos_r + vsni_pkg::POS_W'(1);
      end
      vsni_pkg::DIR_COL_HI: begin
        in_vol = (c_inc < col_cnt);
        np     = pos_r + vsni_pkg::POS_W'(row_cnt);
      end
      vsni_pkg::DIR_SLICE_HI: begin
        in_vol = (s_inc < slice_cnt);
        np     = pos_r + vsni_pkg::POS_W'(plane);
      end
      default: ;
    endcase
  end

  assign hit     = in_vol && (np_x < lp_x);
  assign rd_en   = cmd.self_rd || (cmd.nbr_rd && hit);
  assign rd_addr = cmd.self_rd ? pos_r[AW-1:0] : np[AW-1:0];

  always_comb begin
    lp_nxt = lp_r;
    vc_nxt = vc_r;
    if (cmd.restart) begin
      lp_nxt = '0;
      vc_nxt = '0;
    end else if (wr_en) begin
      lp_nxt = lp_r + LW'(1);
      if (in_word.voxel_valid) begin
        vc_nxt = vc_inc;
      end
    end
  end

  always_comb begin
    tag_nxt          = '0;
    tag_nxt.vld      = cmd.load || cmd.restart || cmd.bad || cmd.self_rd || cmd.nbr_rd;
    tag_nxt.self_cap = cmd.self_rd;
    tag_nxt.nbr      = cmd.nbr_rd;
    tag_nxt.hit      = cmd.nbr_rd && hit;
    tag_nxt.dir      = cmd.dir;
    tag_nxt.status   = vsni_pkg::STAT_OK;
    tag_nxt.last     = cmd.last || cmd.load || cmd.restart || cmd.bad;
    if (cmd.bad) begin
      tag_nxt.status = vsni_pkg::STAT_BAD;
    end else if (cmd.load && !cap_ok) begin
      tag_nxt.status = vsni_pkg::STAT_DROP;
    end else if (cmd.load) begin
      tag_nxt.sidx = load_idx;
      tag_nxt.sint = in_word.intensity;
    end
  end

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = tag_a_r.status;
    out_nxt.last   = tag_a_r.last;
    if (tag_a_r.nbr) begin
      out_nxt.self_index     = self_idx_r;
      out_nxt.self_intensity = self_int_r;
      out_nxt.direction      = tag_a_r.dir;
      if (tag_a_r.hit && (rd_idx_r != '0)) begin
        out_nxt.neighbour_present   = 1'b1;
        out_nxt.neighbour_index     = rd_idx_r;
        out_nxt.neighbour_intensity = rd_int_r;
      end
    end else begin
      out_nxt.self_index     = tag_a_r.sidx;
      out_nxt.self_intensity = tag_a_r.sint;
    end
  end

  // voxel stores: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      idx_mem[lp_r[AW-1:0]] <= load_idx;
      int_mem[lp_r[AW-1:0]] <= in_word.intensity;
    end
    if (rd_en) begin
      rd_idx_r <= idx_mem[rd_addr];
      rd_int_r <= int_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r      <= '0;
      vc_r      <= '0;
      tag_a_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      lp_r      <= lp_nxt;
      vc_r      <= vc_nxt;
      tag_a_r   <= tag_nxt;
      out_vld_r <= tag_a_r.vld && !tag_a_r.self_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      qr_r <= in_word.row;
      qc_r <= in_word.col;
      qs_r <= in_word.slice;
    end
    if (cmd.mul1) begin
      m1_r  <= m1_nxt;
      oob_r <= ({1'b0, qr_r} >= row_cnt) || ({1'b0, qc_r} >= col_cnt)
            || ({1'b0, qs_r} >= slice_cnt);
    end
    if (cmd.mul2) begin
      pos_r <= pos_nxt;
    end
    // hold the queried voxel for its six neighbour words
    if (tag_a_r.vld && tag_a_r.self_cap) begin
      self_idx_r <= rd_idx_r;
      self_int_r <= (rd_idx_r != '0) ? rd_int_r : '0;
    end
    out_word_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule

// ----- design/voxel_six_neighbour_index_top.sv -----
// Top level of the six-neighbour voxel index block: geometry registers and units.
// Usage: a word on in_word is taken at a clock edge with start high and busy low.
// Load words store the next voxel in row-fastest order and give one result word;
// restart words rewind loading and give one result word; query words give six
// neighbour words (or one status word when the voxel is outside or not loaded).
// Each result word sits on out_word for one cycle with out_valid high; the
// receiver cannot stall, so it must take every word as it comes.
// Loads and restarts leave the block idle and may follow back to back; their
// result passes the tag register, then the output register. A query keeps busy
// high while two multiply stages form the voxel position and the single read
// port of the stores serves the voxel and its six neighbours one per cycle;
// its words then pass the read and tag registers and the output register.
// The cfg channel writes row, column and slice counts while the block is idle
// and start is low; busy then stays high while plane and volume settle.
// Reset restores 64 x 64 x 16 geometry and empties the load counters; the
// stores keep stale contents, which are never read before being reloaded.
module voxel_six_neighbour_index_top #(
  parameter int MAX_VOXELS = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  vsni_pkg::in_word_t              in_word,
  output logic                            out_valid,
  output vsni_pkg::out_word_t             out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vsni_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vsni_pkg::CNT_W-1:0]      cfg_data
);

  logic [vsni_pkg::CNT_W-1:0]   row_cnt_r, col_cnt_r, slice_cnt_r;
  logic [vsni_pkg::PLANE_W-1:0] plane_r, plane_nxt;
  logic [vsni_pkg::POS_W-1:0]   vol_r, vol_nxt;
  logic                         cfg_wr, idle, query_ok;
  vsni_pkg::dp_cmd_t            cmd;

  // hold off register writes while a word is being taken
  assign cfg_ready = idle && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign plane_nxt = vsni_pkg::PLANE_W'(row_cnt_r) * vsni_pkg::PLANE_W'(col_cnt_r);
  assign vol_nxt   = vsni_pkg::POS_W'(plane_r) * vsni_pkg::POS_W'(slice_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= vsni_pkg::ROW_RST;
      col_cnt_r   <= vsni_pkg::COL_RST;
      slice_cnt_r <= vsni_pkg::SLICE_RST;
      plane_r     <= vsni_pkg::PLANE_RST;
      vol_r       <= vsni_pkg::VOL_RST;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          vsni_pkg::CFG_ROW:   row_cnt_r   <= cfg_data;
          vsni_pkg::CFG_COL:   col_cnt_r   <= cfg_data;
          vsni_pkg::CFG_SLICE: slice_cnt_r <= cfg_data;
          default: ;
        endcase
      end
      plane_r <= plane_nxt;
      vol_r   <= vol_nxt;
    end
  end

  vsni_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_word.req_type),
    .cfg_wr   (cfg_wr),
    .query_ok (query_ok),
    .busy     (busy),
    .idle     (idle),
    .cmd      (cmd)
  );

  vsni_dp #(
    .MAX_VOXELS (MAX_VOXELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .row_cnt   (row_cnt_r),
    .col_cnt   (col_cnt_r),
    .slice_cnt (slice_cnt_r),
    .plane     (plane_r),
    .vol       (vol_r),
    .query_ok  (query_ok),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ----- bench/voxel_six_neighbour_index_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the six-neighbour voxel index block: loads, queries, restarts, geometry.
module voxel_six_neighbour_index_top_tb;

  localparam int MAX_VOXELS   = 65536;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_GAP      = 40;
  localparam int PHASE_WORDS  = 65;

  // Request code the block has no use for; it must swallow it silently.
  localparam logic [vsni_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [vsni_pkg::DIR_W-1:0] DIR_ORDER [6] = '{
    vsni_pkg::DIR_SLICE_LO, vsni_pkg::DIR_COL_LO, vsni_pkg::DIR_ROW_LO,
    vsni_pkg::DIR_ROW_HI, vsni_pkg::DIR_COL_HI, vsni_pkg::DIR_SLICE_HI};

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  vsni_pkg::in_word_t             in_word;
  logic                           out_valid;
  vsni_pkg::out_word_t            out_word;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [vsni_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vsni_pkg::CNT_W-1:0]     cfg_data;

  // Shadow of the block's volume state.
  logic [vsni_pkg::IDX_W-1:0] vox_index_mem [MAX_VOXELS];
  logic [vsni_pkg::INT_W-1:0] vox_level_mem [MAX_VOXELS];
  int unsigned      next_load_pos = 0;
  int unsigned      valid_total   = 0;
  int unsigned      geo_rows      = 32'(vsni_pkg::ROW_RST);
  int unsigned      geo_cols      = 32'(vsni_pkg::COL_RST);
  int unsigned      geo_slices    = 32'(vsni_pkg::SLICE_RST);

  vsni_pkg::out_word_t pending_words [$];

  int idle_pct      = 0;
  int mismatches    = 0;
  int words_checked = 0;
  int random_items  = 0;
  int n_loads       = 0;
  int n_drops       = 0;
  int n_queries     = 0;
  int n_rejects     = 0;
  int n_restarts    = 0;
  int n_ignored     = 0;
  int n_geometries  = 0;

  voxel_six_neighbour_index_top #(
    .MAX_VOXELS(MAX_VOXELS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d result words still pending", pending_words.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic vsni_pkg::out_word_t status_word(input logic [vsni_pkg::STAT_W-1:0] st);
    vsni_pkg::out_word_t o;
    o        = '0;
    o.status = st;
    o.last   = 1'b1;
    return o;
  endfunction

  function automatic int unsigned volume_capacity();
    int unsigned vol;
    vol = geo_rows * geo_cols * geo_slices;
    return (vol < MAX_VOXELS) ? vol : MAX_VOXELS;
  endfunction

  function automatic int unsigned volume_pos(input int unsigned r, input int unsigned c,
                                             input int unsigned s);
    return (s * geo_cols + c) * geo_rows + r;
  endfunction

  // Advance the shadow state by one accepted word and queue the words it must produce.
  function automatic void predict_voxel_words(input vsni_pkg::in_word_t w);
    vsni_pkg::out_word_t        o;
    int unsigned                r, c, s, pos, nr, nc, ns, np;
    logic [vsni_pkg::IDX_W-1:0] idx;
    logic                       in_bounds;
    logic [vsni_pkg::DIR_W-1:0] dir;
    case (w.req_type)
      vsni_pkg::REQ_LOAD: begin
        n_loads++;
        if (next_load_pos >= volume_capacity()) begin
          n_drops++;
          pending_words.push_back(status_word(vsni_pkg::STAT_DROP));
        end else begin
          idx = '0;
          if (w.voxel_valid) begin
            valid_total = (valid_total + 1) % (1 << vsni_pkg::IDX_W);
            idx = valid_total[vsni_pkg::IDX_W-1:0];
          end
          vox_index_mem[next_load_pos] = idx;
          vox_level_mem[next_load_pos] = w.intensity;
          next_load_pos++;
          o                = status_word(vsni_pkg::STAT_OK);
          o.self_index     = idx;
          o.self_intensity = w.intensity;
          pending_words.push_back(o);
        end
      end
      vsni_pkg::REQ_RESTART: begin
        n_restarts++;
        next_load_pos = 0;
        valid_total   = 0;
        pending_words.push_back(status_word(vsni_pkg::STAT_OK));
      end
      vsni_pkg::REQ_QUERY: begin
        n_queries++;
        r = 32'(w.row);
        c = 32'(w.col);
        s = 32'(w.slice);
        pos = volume_pos(r, c, s);
        if (r >= geo_rows || c >= geo_cols || s >= geo_slices || pos >= next_load_pos) begin
          n_rejects++;
          pending_words.push_back(status_word(vsni_pkg::STAT_BAD));
        end else begin
          for (int k = 0; k < 6; k++) begin
            dir       = DIR_ORDER[k];
            nr        = r;
            nc        = c;
            ns        = s;
            in_bounds = 1'b1;
            case (dir)
              vsni_pkg::DIR_SLICE_LO: if (s == 0) in_bounds = 1'b0; else ns = s - 1;
              vsni_pkg::DIR_COL_LO:   if (c == 0) in_bounds = 1'b0; else nc = c - 1;
              vsni_pkg::DIR_ROW_LO:   if (r == 0) in_bounds = 1'b0; else nr = r - 1;
              vsni_pkg::DIR_ROW_HI: begin
                nr = r + 1;
                in_bounds = nr < geo_rows;
              end
              vsni_pkg::DIR_COL_HI: begin
                nc = c + 1;
                in_bounds = nc < geo_cols;
              end
              default: begin
                ns = s + 1;
                in_bounds = ns < geo_slices;
              end
            endcase
            o                = '0;
            o.status         = vsni_pkg::STAT_OK;
            o.self_index     = vox_index_mem[pos];
            o.self_intensity = (vox_index_mem[pos] != 0) ? vox_level_mem[pos] : '0;
            o.direction      = dir;
            o.last           = (dir == vsni_pkg::DIR_SLICE_HI);
            if (in_bounds) begin
              np = volume_pos(nr, nc, ns);
              if (np < next_load_pos && vox_index_mem[np] != 0) begin
                o.neighbour_present   = 1'b1;
                o.neighbour_index     = vox_index_mem[np];
                o.neighbour_intensity = vox_level_mem[np];
              end
            end
            pending_words.push_back(o);
          end
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  // Compare every result word against the oldest expectation.
  always @(posedge clk) begin : result_check
    vsni_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing pending", out_word));
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_word.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_word.status, want.status));
        if (out_word.self_index !== want.self_index)
          report_mismatch($sformatf("self_index got %0d want %0d",
                                    out_word.self_index, want.self_index));
        if (out_word.self_intensity !== want.self_intensity)
          report_mismatch($sformatf("self_intensity got %0d want %0d",
                                    out_word.self_intensity, want.self_intensity));
        if (out_word.direction !== want.direction)
          report_mismatch($sformatf("direction got %0d want %0d",
                                    out_word.direction, want.direction));
        if (out_word.neighbour_present !== want.neighbour_present)
          report_mismatch($sformatf("neighbour_present got %0d want %0d (dir %0d)",
                                    out_word.neighbour_present, want.neighbour_present,
                                    want.direction));
        if (out_word.neighbour_index !== want.neighbour_index)
          report_mismatch($sformatf("neighbour_index got %0d want %0d (dir %0d)",
                                    out_word.neighbour_index, want.neighbour_index,
                                    want.direction));
        if (out_word.neighbour_intensity !== want.neighbour_intensity)
          report_mismatch($sformatf("neighbour_intensity got %0d want %0d (dir %0d)",
                                    out_word.neighbour_intensity, want.neighbour_intensity,
                                    want.direction));
        if (out_word.last !== want.last)
          report_mismatch($sformatf("last got %0d want %0d", out_word.last, want.last));
      end
    end
  end

  // Unused fields carry random bits so that the block must ignore them.
  function automatic vsni_pkg::in_word_t make_word(input logic [vsni_pkg::REQ_W-1:0] req);
    vsni_pkg::in_word_t w;
    w.req_type    = req;
    w.voxel_valid = 1'($urandom_range(1));
    w.intensity   = vsni_pkg::INT_W'($urandom_range(16'hFFFF));
    w.row         = vsni_pkg::COORD_W'($urandom_range(255));
    w.col         = vsni_pkg::COORD_W'($urandom_range(255));
    w.slice       = vsni_pkg::COORD_W'($urandom_range(255));
    return w;
  endfunction

  function automatic vsni_pkg::in_word_t load_word(input logic ok,
                                                   input logic [vsni_pkg::INT_W-1:0] level);
    vsni_pkg::in_word_t w;
    w             = make_word(vsni_pkg::REQ_LOAD);
    w.voxel_valid = ok;
    w.intensity   = level;
    return w;
  endfunction

  function automatic vsni_pkg::in_word_t query_word(input int unsigned r, input int unsigned c,
                                                    input int unsigned s);
    vsni_pkg::in_word_t w;
    w       = make_word(vsni_pkg::REQ_QUERY);
    w.row   = r[vsni_pkg::COORD_W-1:0];
    w.col   = c[vsni_pkg::COORD_W-1:0];
    w.slice = s[vsni_pkg::COORD_W-1:0];
    return w;
  endfunction

  function automatic logic [vsni_pkg::INT_W-1:0] random_level();
    return vsni_pkg::INT_W'($urandom_range(16'hFFFF));
  endfunction

  // Hold start until the block takes the word, then idle the sender at random.
  task automatic send_word(input vsni_pkg::in_word_t w);
    int gap;
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    predict_voxel_words(w);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop start, let every expected word arrive, then let the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [vsni_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[vsni_pkg::CNT_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      vsni_pkg::CFG_ROW: geo_rows   = value % (1 << vsni_pkg::CNT_W);
      vsni_pkg::CFG_COL: geo_cols   = value % (1 << vsni_pkg::CNT_W);
      default:           geo_slices = value % (1 << vsni_pkg::CNT_W);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned rows, input int unsigned cols,
                              input int unsigned slices);
    cfg_write(vsni_pkg::CFG_ROW, rows);
    cfg_write(vsni_pkg::CFG_COL, cols);
    cfg_write(vsni_pkg::CFG_SLICE, slices);
    n_geometries++;
  endtask

  // Reset geometry, partial load, rejected coordinates, ignored code, restart.
  task automatic test_default_geometry();
    send_word(load_word(1'b1, 16'hFFFF));
    send_word(load_word(1'b0, 16'h0000));
    send_word(load_word(1'b1, 16'h8001));
    send_word(query_word(0, 0, 0));
    send_word(query_word(1, 0, 0));
    send_word(query_word(2, 0, 0));
    send_word(query_word(3, 0, 0));
    send_word(query_word(0, 0, 16));
    send_word(query_word(64, 0, 0));
    send_word(query_word(0, 64, 0));
    send_word(make_word(REQ_UNUSED));
    send_word(make_word(vsni_pkg::REQ_RESTART));
    send_word(query_word(0, 0, 0));
    wait_drained();
  endtask

  // Fill a 2x2x2 volume past capacity, query four of its corners and out-of-range points.
  task automatic test_capacity_and_corners();
    set_geometry(2, 2, 2);
    send_word(make_word(vsni_pkg::REQ_RESTART));
    for (int p = 0; p < 10; p++)
      send_word(load_word(p != 5, random_level()));
    send_word(query_word(0, 0, 0));
    send_word(query_word(1, 1, 1));
    send_word(query_word(1, 0, 1));
    send_word(query_word(0, 1, 1));
    send_word(query_word(2, 0, 0));
    send_word(query_word(0, 2, 0));
    send_word(query_word(0, 0, 2));
    send_word(query_word(255, 255, 255));
    wait_drained();
  endtask

  // Empty, oversized and all-ones geometry; reinterpret a loaded volume.
  task automatic test_geometry_extremes();
    set_geometry(0, 0, 0);
    send_word(make_word(vsni_pkg::REQ_RESTART));
    send_word(load_word(1'b1, 16'h1234));
    send_word(query_word(0, 0, 0));
    wait_drained();

    set_geometry(256, 256, 256);
    for (int p = 0; p < 3; p++)
      send_word(load_word(1'b1, random_level()));
    send_word(query_word(1, 0, 0));
    send_word(query_word(255, 255, 255));
    wait_drained();

    // Keep the loaded voxels and read them back along a single row.
    set_geometry(511, 1, 1);
    send_word(load_word(1'b1, 16'h00FF));
    send_word(load_word(1'b1, 16'hFF00));
    send_word(query_word(4, 0, 0));
    send_word(query_word(0, 0, 0));
    wait_drained();

    set_geometry(1, 1, 511);
    send_word(query_word(0, 0, 4));
    send_word(query_word(0, 0, 5));
    wait_drained();
  endtask

  // One random geometry: restart, load, then mostly sensible queries plus noise.
  task automatic run_volume();
    int unsigned rows, cols, slices, cap, n_load, n_query, p, kind;
    if ($urandom_range(7) == 0) begin
      rows   = $urandom_range(200, 256);
      cols   = 1;
      slices = 1;
      n_load = $urandom_range(0, 24);
    end else begin
      rows   = $urandom_range(1, 6);
      cols   = $urandom_range(1, 5);
      slices = $urandom_range(1, 4);
      cap    = rows * cols * slices;
      n_load = ($urandom_range(9) < 7) ? cap + $urandom_range(0, 2) : $urandom_range(0, cap);
    end
    set_geometry(rows, cols, slices);
    send_word(make_word(vsni_pkg::REQ_RESTART));
    random_items++;
    for (int i = 0; i < n_load; i++) begin
      if ($urandom_range(19) == 0) send_word(make_word(REQ_UNUSED));
      send_word(load_word($urandom_range(99) < 85, random_level()));
      random_items++;
    end
    n_query = $urandom_range(4, 14);
    for (int i = 0; i < n_query; i++) begin
      kind = $urandom_range(99);
      if (kind < 60 && next_load_pos > 0) begin
        p = $urandom_range(next_load_pos - 1);
        send_word(query_word(p % rows, (p / rows) % cols, p / (rows * cols)));
      end else if (kind < 80) begin
        send_word(query_word($urandom_range(rows - 1), $urandom_range(cols - 1),
                             $urandom_range(slices - 1)));
      end else if (kind < 92) begin
        send_word(make_word(vsni_pkg::REQ_QUERY));
      end else if (kind < 96) begin
        send_word(make_word(REQ_UNUSED));
        continue;
      end else begin
        send_word(make_word(vsni_pkg::REQ_RESTART));
      end
      random_items++;
    end
    wait_drained();
  endtask

  task automatic run_random_phase(input int pct, input int words);
    int goal;
    idle_pct = pct;
    goal     = random_items + words;
    while (random_items < goal) run_volume();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, PHASE_WORDS);
    run_random_phase(80, PHASE_WORDS);
    run_random_phase(0, PHASE_WORDS);
    run_random_phase(15, PHASE_WORDS);
    idle_pct = 0;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = vsni_pkg::CFG_ROW;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_geometry();
    test_capacity_and_corners();
    test_geometry_extremes();
    test_random_traffic();

    $display("Covered %0d loads (%0d dropped), %0d queries (%0d rejected),",
             n_loads, n_drops, n_queries, n_rejects);
    $display("  %0d restarts, %0d ignored; %0d result words over %0d geometries, %0d mismatches",
             n_restarts, n_ignored, words_checked, n_geometries, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/vsni_pkg.sv
design/vsni_ctrl.sv
design/vsni_dp.sv
design/voxel_six_neighbour_index_top.sv
bench/voxel_six_neighbour_index_top_tb.sv
